[sv/motb_pkg.sv]
// Shared types, sizes and helpers for the one-shot timer bank.
`timescale 1ns / 1ps
`default_nettype none
package motb_pkg;

    // Bank size and counter width
    localparam int TIMER_SLOTS     = 16;
    localparam int DELAY_BITS      = 16;
    localparam int SLOT_IDX_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CMD_QUEUE_DEPTH = 2;

    // Input kind codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  owner;
        logic [7:0]  event_req;
        logic [15:0] delay;
    } in_item_t;

    typedef struct packed {
        logic [6:0] fired_owner;
        logic [7:0] fired_event;
        logic       last_of_tick;
    } out_item_t;

    // Command passed from the front end to the slot engine
    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        logic [6:0]             owner;
        logic [7:0]             evt;
        logic [DELAY_BITS-1:0]  delay;
    } cmd_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_COMMIT,
        ENG_FLUSH
    } eng_state_t;

    // Saturate a 16-bit request delay to the counter width
    function automatic logic [DELAY_BITS-1:0] clamp_delay(input logic [15:0] d);
        logic [32:0] lim;
        logic [32:0] d_ext;
        lim   = (33'd1 << DELAY_BITS) - 33'd1;
        d_ext = {17'd0, d};
        if (d_ext > lim) begin
            return lim[DELAY_BITS-1:0];
        end
        return d_ext[DELAY_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

[sv/motb_front.sv]
// Front end: accepts input beats, drops no-op requests and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module motb_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire motb_pkg::in_item_t s_data,
    output logic                   q_valid,
    output motb_pkg::cmd_t         q_cmd,
    input  wire logic              q_pop
);
    import motb_pkg::*;

    localparam int QPTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t              cmd_mem_reg [CMD_QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              cmd_in;
    logic              keep;
    logic              push;
    logic              pop;

    // Classify: ticks always, start and stop only with a real owner
    always_comb begin
        keep          = 1'b0;
        cmd_in.op     = OP_TICK;
        cmd_in.owner  = s_data.owner;
        cmd_in.evt    = s_data.event_req;
        cmd_in.delay  = clamp_delay(s_data.delay);
        case (s_data.kind)
            KIND_TICK: begin
                keep = 1'b1;
            end
            KIND_START: begin
                cmd_in.op = OP_START;
                keep      = (s_data.owner != 7'd0);
            end
            KIND_STOP: begin
                cmd_in.op = OP_STOP;
                keep      = (s_data.owner != 7'd0);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (count_reg < QCNT_W'(CMD_QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;
    assign pop     = q_pop && (count_reg != '0);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = cmd_mem_reg[rd_ptr_reg];

    // Advance queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued commands
    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(CMD_QUEUE_DEPTH))
        else $error("command queue overfilled");

endmodule
`default_nettype wire

[sv/motb_engine.sv]
// Slot engine: walks the timer slots once per command and emits expiries.
`timescale 1ns / 1ps
`default_nettype none
module motb_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire motb_pkg::cmd_t     q_cmd,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output motb_pkg::out_item_t     m_data
);
    import motb_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] SLOT_LAST = SLOT_IDX_W'(TIMER_SLOTS - 1);

    // Slot state
    logic [6:0]            slot_owner_reg [TIMER_SLOTS];
    logic [6:0]            slot_owner_next [TIMER_SLOTS];
    logic [7:0]            slot_event_reg [TIMER_SLOTS];
    logic [7:0]            slot_event_next [TIMER_SLOTS];
    logic [DELAY_BITS-1:0] slot_rem_reg [TIMER_SLOTS];
    logic [DELAY_BITS-1:0] slot_rem_next [TIMER_SLOTS];

    // Sequencer state
    eng_state_t            state_reg, state_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  match_found_reg, match_found_next;
    logic [SLOT_IDX_W-1:0] match_idx_reg, match_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [SLOT_IDX_W-1:0] free_idx_reg, free_idx_next;

    // Held expiry, released once the next one (or the end of the tick) is known
    logic                  pend_valid_reg, pend_valid_next;
    logic [6:0]            pend_owner_reg, pend_owner_next;
    logic [7:0]            pend_event_reg, pend_event_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic [6:0]            cur_owner;
    logic [7:0]            cur_event;
    logic [DELAY_BITS-1:0] cur_rem;
    logic                  cur_active;
    logic                  cur_expire;
    logic                  out_free;
    logic                  tick_stall;
    logic                  scan_last;

    assign cur_owner  = slot_owner_reg[idx_reg];
    assign cur_event  = slot_event_reg[idx_reg];
    assign cur_rem    = slot_rem_reg[idx_reg];
    assign cur_active = (cur_owner != 7'd0);
    assign cur_expire = (cur_rem <= DELAY_BITS'(1));
    assign out_free   = !m_valid_reg || m_ready;
    assign scan_last  = (idx_reg == SLOT_LAST);
    assign tick_stall = (state_reg == ENG_SCAN) && (cmd_reg.op == OP_TICK) && cur_active
                        && cur_expire && pend_valid_reg && !out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: begin
                if (q_valid) begin
                    state_next = ENG_SCAN;
                end
            end
            ENG_SCAN: begin
                if (scan_last && !tick_stall) begin
                    case (cmd_reg.op)
                        OP_START: state_next = ENG_COMMIT;
                        OP_TICK: begin
                            if (pend_valid_reg || (cur_active && cur_expire)) begin
                                state_next = ENG_FLUSH;
                            end else begin
                                state_next = ENG_IDLE;
                            end
                        end
                        default: state_next = ENG_IDLE;
                    endcase
                end
            end
            ENG_COMMIT: begin
                state_next = ENG_IDLE;
            end
            ENG_FLUSH: begin
                if (out_free) begin
                    state_next = ENG_IDLE;
                end
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        q_pop = 1'b0;
        case (state_reg)
            ENG_IDLE: q_pop = q_valid;
            default:  q_pop = 1'b0;
        endcase
    end

    // Slot updates, expiry hand-off and output register
    always_comb begin
        logic      out_push;
        out_item_t out_beat;

        slot_owner_next  = slot_owner_reg;
        slot_event_next  = slot_event_reg;
        slot_rem_next    = slot_rem_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_owner_next  = pend_owner_reg;
        pend_event_next  = pend_event_reg;
        out_push                = 1'b0;
        out_beat.fired_owner    = pend_owner_reg;
        out_beat.fired_event    = pend_event_reg;
        out_beat.last_of_tick   = 1'b0;

        case (state_reg)
            ENG_IDLE: begin
                // Take the next command and start a fresh sweep
                if (q_valid) begin
                    cmd_next         = q_cmd;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                end
            end
            ENG_SCAN: begin
                case (cmd_reg.op)
                    OP_START: begin
                        // Note the matching slot and the first free one
                        if (!match_found_reg && cur_owner == cmd_reg.owner
                            && cur_event == cmd_reg.evt) begin
                            match_found_next = 1'b1;
                            match_idx_next   = idx_reg;
                        end
                        if (!free_found_reg && !cur_active) begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    OP_STOP: begin
                        // Drop the matching slot; event zero drops all of the owner's
                        if (cur_owner == cmd_reg.owner
                            && (cmd_reg.evt == 8'd0 || cur_event == cmd_reg.evt)) begin
                            slot_owner_next[idx_reg] = 7'd0;
                            slot_event_next[idx_reg] = 8'd0;
                            slot_rem_next[idx_reg]   = '0;
                        end
                    end
                    default: begin
                        // Count down, or expire and hold the expiry
                        if (cur_active && !tick_stall) begin
                            if (cur_expire) begin
                                out_push                 = pend_valid_reg;
                                pend_valid_next          = 1'b1;
                                pend_owner_next          = cur_owner;
                                pend_event_next          = cur_event;
                                slot_owner_next[idx_reg] = 7'd0;
                                slot_event_next[idx_reg] = 8'd0;
                                slot_rem_next[idx_reg]   = '0;
                            end else begin
                                slot_rem_next[idx_reg] = cur_rem - 1'b1;
                            end
                        end
                    end
                endcase
                if (!tick_stall) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ENG_COMMIT: begin
                // Retrigger the match, else claim the first free slot
                if (match_found_reg) begin
                    slot_rem_next[match_idx_reg] = cmd_reg.delay;
                end else if (free_found_reg) begin
                    slot_owner_next[free_idx_reg] = cmd_reg.owner;
                    slot_event_next[free_idx_reg] = cmd_reg.evt;
                    slot_rem_next[free_idx_reg]   = cmd_reg.delay;
                end
            end
            ENG_FLUSH: begin
                // Release the final expiry of the tick, marked as last
                if (out_free) begin
                    out_push              = 1'b1;
                    out_beat.last_of_tick = 1'b1;
                    pend_valid_next       = 1'b0;
                end
            end
            default: begin
            end
        endcase

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_push) begin
            m_valid_next = 1'b1;
            m_data_next  = out_beat;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ENG_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                slot_owner_reg[i] <= 7'd0;
                slot_event_reg[i] <= 8'd0;
                slot_rem_reg[i]   <= '0;
            end
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            slot_owner_reg <= slot_owner_next;
            slot_event_reg <= slot_event_next;
            slot_rem_reg   <= slot_rem_next;
        end
    end

    // Sweep payload
    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        cmd_reg         <= cmd_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        pend_owner_reg  <= pend_owner_next;
        pend_event_reg  <= pend_event_next;
        m_data_reg      <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_flush_has_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ENG_FLUSH |-> pend_valid_reg)
        else $error("flush without a held expiry");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ENG_IDLE |-> !pend_valid_reg)
        else $error("expiry left behind after a tick");

    a_stall_holds_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_stall |=> $stable(idx_reg) && state_reg == ENG_SCAN)
        else $error("sweep advanced while output was blocked");

endmodule
`default_nettype wire

[sv/multiplexed_oneshot_timer_bank.sv]
// Top level of the one-shot timer bank: front end, command queue and slot engine.
`timescale 1ns / 1ps
`default_nettype none
// Sixteen one-shot timers share one time base. Each command (tick, start,
// stop) is queued by the front end and then carried out by one sweep of the
// slot engine over all slots, one slot per cycle. A stop, or a tick with
// nothing expiring, is a dispatch step followed by one scan step per slot.
// A start, or a tick that fires, adds one more step, to write back the start
// or release the last expiry of the tick. Expiries of a tick leave in
// ascending slot order, one beat per cycle at most; a stalled result
// channel stretches the sweep. Two commands can wait in the queue while a
// sweep is under way. Start and stop with owner zero and the unused kind
// code are dropped at the input.
module multiplexed_oneshot_timer_bank (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire motb_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output motb_pkg::out_item_t      m_data
);
    import motb_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    motb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    motb_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
